[src/tle_pkg.sv]
`default_nettype none

package tle_pkg;

  // Line store geometry
  localparam int unsigned LINE_DEPTH = 4096;
  localparam int unsigned ADDR_W     = $clog2(LINE_DEPTH);
  localparam int unsigned LEN_W      = ADDR_W + 1;

  // Request opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_ECHO    = 3'd1;
  localparam logic [2:0] KIND_DATA    = 3'd2;
  localparam logic [2:0] KIND_INTR    = 3'd3;
  localparam logic [2:0] KIND_EOF     = 3'd4;
  localparam logic [2:0] KIND_REFUSED = 3'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL    = 2'd2;

  // Escape parser states
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_SEEN = 2'd1;
  localparam logic [1:0] ESC_SEQ  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_ETX      = 8'h03;
  localparam logic [7:0] CH_EOT      = 8'h04;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_SS3      = 8'h4F;
  localparam logic [7:0] CH_CSI      = 8'h5B;
  localparam logic [7:0] CH_FINAL_LO = 8'h40;
  localparam logic [7:0] CH_FINAL_HI = 8'h7E;
  localparam logic [7:0] CH_DEL      = 8'h7F;

  // Pending result group for one request
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       eol;
    logic [1:0] cnt;       // number of results, 1 or 3
    logic       bs_seq;    // backspace, space, backspace echo
    logic       from_ram;  // data byte comes from the line store
  } tle_res_t;

endpackage

`default_nettype wire

[src/tle_key_if.sv]
`default_nettype none

interface tle_key_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] key_byte;

  modport source (output valid, opcode, key_byte, input ready);
  modport sink   (input valid, opcode, key_byte, output ready);
endinterface

`default_nettype wire

[src/tle_res_if.sv]
`default_nettype none

interface tle_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] out_byte;
  logic       end_of_line;
  logic       last;

  modport source (output valid, kind, out_byte, end_of_line, last, input ready);
  modport sink   (input valid, kind, out_byte, end_of_line, last, output ready);
endinterface

`default_nettype wire

[src/tty_line_editor.sv]
// Channel   Dir  Payload                               Handshake
// key_in    in   opcode, key_byte                      valid / ready
// res_out   out  kind, out_byte, end_of_line, last     valid / ready
// cfg       in   cfg_idx_i, cfg_data_i                 cfg_we_i, no wait
//
// A request is taken on its valid / ready handshake; its 1 or 3 results leave from
// the result register one per cycle while res_out is ready.
// The next request is taken in the cycle the last result of the previous one
// is taken. Stalls on res_out hold the result register and the line store read data.
// Reset (rst_ni, async) clears the line state and restores all config bits to 1;
// the line store has no reset and needs no clearing pass.
`default_nettype none

module tty_line_editor
  import tle_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  tle_key_if.sink                   key_in,
  tle_res_if.source                 res_out,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic                 cfg_data_i
);

  logic             canon_q, echo_q, sig_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] rpos_q, rpos_d;
  logic [LEN_W-1:0] rpos_inc;
  logic             rdy_q, rdy_d;
  logic             eof_q, eof_d;
  logic [1:0]       esc_q, esc_d;
  tle_res_t         p_q, res_d;
  logic             p_valid_q;
  logic [1:0]       slot_q;
  logic [7:0]       key_c;
  logic [7:0]       ram_rdata;
  logic             wr_en, rd_en;
  logic             in_acc, out_acc, out_last;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canon_q <= 1'b1;
      echo_q  <= 1'b1;
      sig_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CANONICAL: canon_q <= cfg_data_i;
        CFG_ECHO:      echo_q  <= cfg_data_i;
        CFG_SIGNAL:    sig_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshakes
  assign out_last     = (slot_q == (p_q.cnt - 2'd1));
  assign out_acc      = res_out.valid & res_out.ready;
  assign key_in.ready = !p_valid_q || (res_out.ready && out_last);
  assign in_acc       = key_in.valid & key_in.ready;

  assign key_c    = (key_in.key_byte == CH_CR) ? CH_LF : key_in.key_byte;
  assign rpos_inc = rpos_q + LEN_W'(1);

  // Line editing and read decode for the incoming request
  always_comb begin
    len_d  = len_q;
    rpos_d = rpos_q;
    rdy_d  = rdy_q;
    eof_d  = eof_q;
    esc_d  = esc_q;
    wr_en  = 1'b0;
    rd_en  = 1'b0;
    res_d  = '{kind: KIND_NONE, data: 8'h00, eol: 1'b0, cnt: 2'd1,
               bs_seq: 1'b0, from_ram: 1'b0};
    if (key_in.opcode == OP_KEY) begin
      if (!canon_q) begin
        if (sig_q && key_in.key_byte == CH_ETX) begin
          res_d.kind = KIND_INTR;
        end else begin
          res_d.kind = KIND_DATA;
          res_d.data = key_in.key_byte;
        end
      end else if (rdy_q) begin
        res_d.kind = KIND_REFUSED;
      end else if (esc_q == ESC_SEEN) begin
        esc_d = (key_in.key_byte inside {CH_CSI, CH_SS3}) ? ESC_SEQ : ESC_NONE;
      end else if (esc_q != ESC_NONE) begin
        if (key_in.key_byte inside {[CH_FINAL_LO:CH_FINAL_HI]}) begin
          esc_d = ESC_NONE;
        end
      end else if (sig_q && key_in.key_byte == CH_ETX) begin
        len_d      = '0;
        rpos_d     = '0;
        rdy_d      = 1'b0;
        eof_d      = 1'b0;
        res_d.kind = KIND_INTR;
      end else if (key_in.key_byte == CH_EOT) begin
        rdy_d = 1'b1;
        eof_d = 1'b1;
      end else if (key_in.key_byte == CH_ESC) begin
        esc_d = ESC_SEEN;
      end else if (key_in.key_byte inside {CH_BS, CH_DEL}) begin
        if (len_q != '0) begin
          len_d = len_q - LEN_W'(1);
          if (echo_q) begin
            res_d.kind   = KIND_ECHO;
            res_d.cnt    = 2'd3;
            res_d.bs_seq = 1'b1;
          end
        end
      end else begin
        if (len_q < LEN_W'(LINE_DEPTH)) begin
          wr_en = 1'b1;
          len_d = len_q + LEN_W'(1);
          if (echo_q && (key_c == CH_LF || key_c >= CH_SPACE)) begin
            res_d.kind = KIND_ECHO;
            res_d.data = key_c;
          end
        end
        if (key_c == CH_LF) begin
          rdy_d = 1'b1;
        end
      end
    end else if (canon_q && rdy_q) begin
      if (len_q == '0 || rpos_q >= len_q) begin
        if (len_q == '0 && eof_q) begin
          res_d.kind = KIND_EOF;
        end
        len_d  = '0;
        rpos_d = '0;
        rdy_d  = 1'b0;
        eof_d  = 1'b0;
      end else begin
        rd_en          = 1'b1;
        res_d.kind     = KIND_DATA;
        res_d.from_ram = 1'b1;
        if (rpos_inc >= len_q) begin
          res_d.eol = 1'b1;
          len_d     = '0;
          rpos_d    = '0;
          rdy_d     = 1'b0;
          eof_d     = 1'b0;
        end else begin
          rpos_d = rpos_inc;
        end
      end
    end
  end

  // Line state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      rpos_q <= '0;
      rdy_q  <= 1'b0;
      eof_q  <= 1'b0;
      esc_q  <= ESC_NONE;
    end else if (in_acc) begin
      len_q  <= len_d;
      rpos_q <= rpos_d;
      rdy_q  <= rdy_d;
      eof_q  <= eof_d;
      esc_q  <= esc_d;
    end
  end

  // Line store
  tle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc & wr_en),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (key_c),
    .re_i    (in_acc & rd_en),
    .raddr_i (rpos_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Result register and slot counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      slot_q    <= 2'd0;
    end else if (in_acc) begin
      p_valid_q <= 1'b1;
      slot_q    <= 2'd0;
    end else if (out_acc) begin
      if (out_last) begin
        p_valid_q <= 1'b0;
        slot_q    <= 2'd0;
      end else begin
        slot_q <= slot_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_q <= res_d;
    end
  end

  // Output drive
  assign res_out.valid       = p_valid_q;
  assign res_out.kind        = p_q.kind;
  assign res_out.end_of_line = p_q.eol;
  assign res_out.last        = out_last;
  assign res_out.out_byte    = p_q.from_ram ? ram_rdata :
                               p_q.bs_seq   ? ((slot_q == 2'd1) ? CH_SPACE : CH_BS) :
                               p_q.data;

  // Checks
  a_rpos_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpos_q <= len_q) else $error("read position past line length");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(LINE_DEPTH)) else $error("line length beyond store depth");

  a_eof_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_q |-> rdy_q) else $error("eof flag without a completed line");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_valid_q |-> (slot_q < p_q.cnt)) else $error("result slot past group size");

  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && key_in.opcode == OP_KEY && canon_q && rdy_q)
      |=> (p_q.kind == KIND_REFUSED && p_valid_q))
    else $error("key during waiting line not refused");

endmodule

`default_nettype wire

[src/tle_ram.sv]
`default_nettype none

module tle_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
